@@ rtl/rpt_pkg.sv @@
`default_nettype none

package rpt_pkg;

  // Default geometry of the table
  localparam int NUM_FRAMES_DEF = 64;
  localparam int LEVELS_DEF     = 5;
  localparam int INDEX_BITS_DEF = 9;

  // Fixed field widths
  localparam int TYPE_W    = 2;
  localparam int VPN_W     = 45;
  localparam int PPN_W     = 52;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Bits folded into the frame residue per cycle
  localparam int MOD_STEP_BITS = 4;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_MAP   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_UNMAP = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_FRAME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 1'd1;

  localparam logic [CFG_W-1:0] FIRST_FREE_RST = 6'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_ALLOC,
    ST_LEAF,
    ST_UNMAP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_MISS,
    RES_HIT,
    RES_DONE,
    RES_OOF
  } res_kind_t;

  typedef struct packed {
    logic      clr;
    logic      in_ready;
    logic      start;
    logic      rd;
    logic      chk;
    logic      adv;
    logic      alloc;
    logic      wr_leaf;
    logic      wr_unmap;
    logic      res_load;
    res_kind_t res_kind;
    logic      push;
  } rpt_cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic              in_valid;
    logic [TYPE_W-1:0] req_type;
    logic              hit;
    logic              last;
    logic              over;
    logic              last_alloc;
    logic              mod_done;
    logic              out_free;
  } rpt_sts_t;

endpackage

`default_nettype wire

@@ rtl/rpt_if.sv @@
`default_nettype none

interface rpt_req_if;
  logic                             valid;
  logic                             ready;
  logic [rpt_pkg::TYPE_W-1:0]       req_type;
  logic [rpt_pkg::VPN_W-1:0]        vpn;
  logic [rpt_pkg::PPN_W-1:0]        ppn;

  modport source (output valid, output req_type, output vpn, output ppn, input ready);
  modport sink   (input valid, input req_type, input vpn, input ppn, output ready);
endinterface

interface rpt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [rpt_pkg::PPN_W-1:0]        ppn_out;
  logic                             out_of_frames;

  modport source (output valid, output found, output ppn_out, output out_of_frames,
                  input ready);
  modport sink   (input valid, input found, input ppn_out, input out_of_frames,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/rpt_mod.sv @@
`default_nettype none

// Serial residue of a page number modulo the frame count, MSB first.
module rpt_mod #(
  parameter int NUM_FRAMES = rpt_pkg::NUM_FRAMES_DEF,
  parameter int FRAME_W    = $clog2(NUM_FRAMES)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rpt_pkg::PPN_W-1:0] value,
  output logic                           done,
  output logic [FRAME_W-1:0]             rem
);

  localparam int STEP  = rpt_pkg::MOD_STEP_BITS;
  localparam int STEPS = (rpt_pkg::PPN_W + STEP - 1) / STEP;
  localparam int PAD_W = STEPS * STEP;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic [FRAME_W:0] N_EXT = (FRAME_W + 1)'(NUM_FRAMES);

  logic [PAD_W-1:0]   sh;
  logic [FRAME_W-1:0] r;
  logic [FRAME_W-1:0] r_next;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  always_comb begin
    logic [FRAME_W:0] t;
    r_next = r;
    for (int k = 0; k < STEP; k++) begin
      t = {r_next, sh[PAD_W-1-k]};
      if (t >= N_EXT) begin
        t = t - N_EXT;
      end
      r_next = t[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= PAD_W'(value);
      r  <= '0;
    end else if (busy) begin
      sh <= sh << STEP;
      r  <= r_next;
    end
  end

  assign done = !busy;
  assign rem  = r;

endmodule

`default_nettype wire

@@ rtl/rpt_ctrl.sv @@
`default_nettype none

module rpt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rpt_pkg::rpt_sts_t sts,
  output rpt_pkg::rpt_cmd_t      cmd
);

  rpt_pkg::state_t state;
  rpt_pkg::state_t state_next;
  logic            walk_on;

  assign walk_on = sts.hit && !sts.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rpt_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_next = rpt_pkg::ST_IDLE;
      end
      rpt_pkg::ST_IDLE: begin
        if (sts.in_valid) state_next = rpt_pkg::ST_RD;
      end
      rpt_pkg::ST_RD: state_next = rpt_pkg::ST_CHK;
      rpt_pkg::ST_CHK: begin
        unique case (sts.req_type)
          rpt_pkg::REQ_QUERY: begin
            state_next = walk_on ? rpt_pkg::ST_RD : rpt_pkg::ST_DONE;
          end
          rpt_pkg::REQ_MAP: begin
            if (walk_on)       state_next = rpt_pkg::ST_RD;
            else if (sts.over) state_next = rpt_pkg::ST_DONE;
            else if (sts.last) state_next = rpt_pkg::ST_LEAF;
            else               state_next = rpt_pkg::ST_ALLOC;
          end
          rpt_pkg::REQ_UNMAP: begin
            if (walk_on)       state_next = rpt_pkg::ST_RD;
            else if (sts.last) state_next = rpt_pkg::ST_UNMAP;
            else               state_next = rpt_pkg::ST_DONE;
          end
          default: state_next = rpt_pkg::ST_DONE;
        endcase
      end
      rpt_pkg::ST_ALLOC: begin
        if (sts.last_alloc) state_next = rpt_pkg::ST_LEAF;
      end
      rpt_pkg::ST_LEAF: begin
        if (sts.mod_done) state_next = rpt_pkg::ST_DONE;
      end
      rpt_pkg::ST_UNMAP: state_next = rpt_pkg::ST_DONE;
      rpt_pkg::ST_DONE: begin
        if (sts.out_free) state_next = rpt_pkg::ST_IDLE;
      end
      default: state_next = rpt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      rpt_pkg::ST_CLEAR: cmd.clr = 1'b1;
      rpt_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.start    = sts.in_valid;
      end
      rpt_pkg::ST_RD: cmd.rd = 1'b1;
      rpt_pkg::ST_CHK: begin
        cmd.chk = 1'b1;
        unique case (sts.req_type)
          rpt_pkg::REQ_QUERY: begin
            cmd.adv      = walk_on;
            cmd.res_load = !walk_on;
            cmd.res_kind = sts.hit ? rpt_pkg::RES_HIT : rpt_pkg::RES_MISS;
          end
          rpt_pkg::REQ_MAP: begin
            cmd.adv      = walk_on;
            cmd.res_load = !walk_on && sts.over;
            cmd.res_kind = rpt_pkg::RES_OOF;
          end
          rpt_pkg::REQ_UNMAP: begin
            cmd.adv      = walk_on;
            cmd.res_load = !walk_on && !sts.last;
            cmd.res_kind = rpt_pkg::RES_MISS;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = rpt_pkg::RES_MISS;
          end
        endcase
      end
      rpt_pkg::ST_ALLOC: cmd.alloc = 1'b1;
      rpt_pkg::ST_LEAF: begin
        cmd.wr_leaf  = sts.mod_done;
        cmd.res_load = sts.mod_done;
        cmd.res_kind = rpt_pkg::RES_DONE;
      end
      rpt_pkg::ST_UNMAP: begin
        cmd.wr_unmap = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = rpt_pkg::RES_DONE;
      end
      rpt_pkg::ST_DONE: cmd.push = sts.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_free)
    else $error("result pushed into an occupied output register");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == rpt_pkg::ST_CHK |-> $past(state) == rpt_pkg::ST_RD)
    else $error("entry checked without a preceding read");

  a_alloc_map: assert property (@(posedge clk) disable iff (rst)
    state == rpt_pkg::ST_ALLOC |-> sts.req_type == rpt_pkg::REQ_MAP)
    else $error("frame allocated outside a map request");
`endif

endmodule

`default_nettype wire

@@ rtl/rpt_dp.sv @@
`default_nettype none

module rpt_dp #(
  parameter int NUM_FRAMES = rpt_pkg::NUM_FRAMES_DEF,
  parameter int LEVELS     = rpt_pkg::LEVELS_DEF,
  parameter int INDEX_BITS = rpt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rpt_pkg::rpt_cmd_t             cmd,
  output rpt_pkg::rpt_sts_t                  sts,
  input  wire logic                          cfg_we,
  input  wire logic [rpt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rpt_pkg::CFG_W-1:0]     cfg_data,
  rpt_req_if.sink                            req,
  rpt_rsp_if.source                          rsp
);

  localparam int PPN_W    = rpt_pkg::PPN_W;
  localparam int CFG_W    = rpt_pkg::CFG_W;
  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int GEN_W    = $clog2(NUM_FRAMES + 1);
  localparam int ENTRIES  = 1 << INDEX_BITS;
  localparam int DEPTH    = NUM_FRAMES * ENTRIES;
  localparam int ADDR_W   = FRAME_W + INDEX_BITS;
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int VX_W     = (LEVELS * INDEX_BITS > rpt_pkg::VPN_W) ?
                            LEVELS * INDEX_BITS : rpt_pkg::VPN_W;
  localparam int SUM_W    = ((CFG_W > GEN_W) ? CFG_W : GEN_W) + 2;
  // Entry layout: {tag, frame residue, number, valid}
  localparam int E_FR_LO  = 1 + PPN_W;
  localparam int E_TAG_LO = E_FR_LO + FRAME_W;
  localparam int ENTRY_W  = E_TAG_LO + GEN_W;
  localparam logic [FRAME_W:0] N_EXT = (FRAME_W + 1)'(NUM_FRAMES);

  // Frame memory plus one generation tag per frame
  logic [ENTRY_W-1:0] emem [DEPTH];
  logic [GEN_W-1:0]   gmem [NUM_FRAMES];

  logic [FRAME_W-1:0]         root_frame;
  logic [CFG_W-1:0]           first_free;
  logic [GEN_W-1:0]           frames_used;
  logic [ADDR_W-1:0]          clr_cnt;

  logic [rpt_pkg::TYPE_W-1:0] cur_type;
  logic [rpt_pkg::VPN_W-1:0]  cur_vpn;
  logic [PPN_W-1:0]           cur_ppn;
  logic [FRAME_W-1:0]         frame;
  logic [LVL_W-1:0]           lvl;
  logic [GEN_W-1:0]           cur_gen;
  logic [ENTRY_W-1:0]         erd;
  logic [GEN_W-1:0]           gen_q;

  logic                       res_found;
  logic [PPN_W-1:0]           res_ppn;
  logic                       res_oof;
  logic                       rsp_valid;
  logic                       out_found;
  logic [PPN_W-1:0]           out_ppn;
  logic                       out_oof;

  logic [FRAME_W-1:0]         root_red;
  logic [VX_W-1:0]            vx;
  logic [INDEX_BITS-1:0]      idx;
  logic [ADDR_W-1:0]          addr;
  logic                       e_valid;
  logic [PPN_W-1:0]           e_num;
  logic [FRAME_W-1:0]         e_fr;
  logic [GEN_W-1:0]           e_tag;
  logic [SUM_W-1:0]           next_sum;
  logic [SUM_W-1:0]           needed;
  logic [FRAME_W-1:0]         nf;
  logic [GEN_W-1:0]           newgen;
  logic [GEN_W-1:0]           link_tag;
  logic                       mod_done;
  logic [FRAME_W-1:0]         ppn_mod;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [ENTRY_W-1:0]         mem_wdata;
  logic                       gen_we;
  logic [FRAME_W-1:0]         gen_waddr;
  logic [GEN_W-1:0]           gen_wdata;

  rpt_mod #(
    .NUM_FRAMES (NUM_FRAMES),
    .FRAME_W    (FRAME_W)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .value (req.ppn),
    .done  (mod_done),
    .rem   (ppn_mod)
  );

  // Reduce the written root frame modulo the frame count
  always_comb begin
    logic [FRAME_W:0] rr;
    rr = '0;
    for (int k = CFG_W - 1; k >= 0; k--) begin
      rr = {rr[FRAME_W-1:0], cfg_data[k]};
      if (rr >= N_EXT) begin
        rr = rr - N_EXT;
      end
    end
    root_red = rr[FRAME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame <= '0;
      first_free <= rpt_pkg::FIRST_FREE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rpt_pkg::REG_ROOT_FRAME: root_frame <= root_red;
        rpt_pkg::REG_FIRST_FREE: first_free <= cfg_data;
        default: first_free <= first_free;
      endcase
    end
  end

  assign vx      = VX_W'(cur_vpn);
  assign idx     = vx[(LEVELS - 1 - int'(lvl)) * INDEX_BITS +: INDEX_BITS];
  assign addr    = {frame, idx};

  assign e_valid = erd[0];
  assign e_num   = erd[PPN_W:1];
  assign e_fr    = erd[E_FR_LO +: FRAME_W];
  assign e_tag   = erd[E_TAG_LO +: GEN_W];

  assign next_sum = SUM_W'(first_free) + SUM_W'(frames_used);
  assign needed   = SUM_W'(LEVELS - 1) - SUM_W'(lvl);
  assign nf       = next_sum[FRAME_W-1:0];
  assign newgen   = frames_used + 1'b1;
  // A fresh frame can be the one holding the link; then the link lands after zeroing
  assign link_tag = (nf == frame) ? newgen : cur_gen;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
    end else if (cmd.alloc) begin
      mem_we    = 1'b1;
      mem_wdata = {link_tag, nf, PPN_W'(nf), 1'b1};
    end else if (cmd.wr_leaf) begin
      mem_we    = 1'b1;
      mem_wdata = {cur_gen, ppn_mod, cur_ppn, 1'b1};
    end else if (cmd.wr_unmap) begin
      mem_we    = 1'b1;
      mem_wdata = {cur_gen, FRAME_W'(0), PPN_W'(0), 1'b0};
    end
  end

  always_comb begin
    gen_we    = 1'b0;
    gen_waddr = nf;
    gen_wdata = newgen;
    if (cmd.clr) begin
      gen_we    = clr_cnt < ADDR_W'(NUM_FRAMES);
      gen_waddr = clr_cnt[FRAME_W-1:0];
      gen_wdata = '0;
    end else if (cmd.alloc) begin
      gen_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      emem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      erd <= emem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gmem[gen_waddr] <= gen_wdata;
    end
    if (cmd.rd) begin
      gen_q <= gmem[frame];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      frames_used <= '0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.alloc) frames_used <= newgen;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_type <= req.req_type;
      cur_vpn  <= req.vpn;
      cur_ppn  <= req.ppn;
      frame    <= root_frame;
      lvl      <= '0;
    end else if (cmd.chk) begin
      cur_gen <= gen_q;
      if (cmd.adv) begin
        frame <= e_fr;
        lvl   <= lvl + 1'b1;
      end
    end else if (cmd.alloc) begin
      frame   <= nf;
      cur_gen <= newgen;
      lvl     <= lvl + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_found <= 1'b0;
      res_ppn   <= '0;
      res_oof   <= 1'b0;
      case (cmd.res_kind)
        rpt_pkg::RES_HIT: begin
          res_found <= 1'b1;
          res_ppn   <= e_num;
        end
        rpt_pkg::RES_DONE: res_found <= 1'b1;
        rpt_pkg::RES_OOF:  res_oof   <= 1'b1;
        default:           res_found <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_found <= res_found;
      out_ppn   <= res_ppn;
      out_oof   <= res_oof;
    end
  end

  assign req.ready         = cmd.in_ready;
  assign rsp.valid         = rsp_valid;
  assign rsp.found         = out_found;
  assign rsp.ppn_out       = out_ppn;
  assign rsp.out_of_frames = out_oof;

  always_comb begin
    sts            = '0;
    sts.clr_done   = clr_cnt == ADDR_W'(DEPTH - 1);
    sts.in_valid   = req.valid;
    sts.req_type   = cur_type;
    sts.hit        = e_valid && (e_tag == gen_q);
    sts.last       = lvl == LVL_W'(LEVELS - 1);
    sts.over       = (next_sum + needed) > SUM_W'(NUM_FRAMES);
    sts.last_alloc = lvl == LVL_W'(LEVELS - 2);
    sts.mod_done   = mod_done;
    sts.out_free   = !rsp_valid || rsp.ready;
  end

`ifndef NO_ASSERTIONS
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (FRAME_W + 1)'(frame) < N_EXT)
    else $error("table frame outside the frame memory");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> next_sum < SUM_W'(NUM_FRAMES))
    else $error("frame handed out beyond the pool");

  a_leaf_residue: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_leaf |-> mod_done)
    else $error("leaf written before its frame residue settled");
`endif

endmodule

`default_nettype wire

@@ rtl/radix_page_table_walker.sv @@
`default_nettype none

// Radix page table walker with a private frame memory of NUM_FRAMES frames of
// 2^INDEX_BITS entries. A request transfer on req carries a type (query, map,
// unmap), a virtual page number split into LEVELS indices of INDEX_BITS bits,
// top level first, and a page number for map. The walk starts at root_frame
// (config index 0) and reads one entry per level, each level in a read state
// and a check state on the single synchronous read port of the frame memory.
// A query returns the leaf page number; a map takes each missing inner table
// from a bump allocator that starts at first_free (config index 1) and then
// writes the leaf; an unmap clears the leaf valid bit. A map that needs more
// frames than remain returns out_of_frames and changes nothing. One result
// transfer on rsp follows every request. Items are handled one at a time: the
// next request is accepted only after the last result has entered the output
// register. The leaf write of a map also waits for the page-number residue
// unit, which starts at acceptance. New frames are zeroed through a per-frame
// generation tag. After reset the block runs a clearing pass over the whole
// frame memory and accepts no request until it is over; configuration
// writes are taken at any time but must only be issued while no request is
// in flight.
module radix_page_table_walker #(
  parameter int NUM_FRAMES = rpt_pkg::NUM_FRAMES_DEF,
  parameter int LEVELS     = rpt_pkg::LEVELS_DEF,
  parameter int INDEX_BITS = rpt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rpt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rpt_pkg::CFG_W-1:0]     cfg_data,
  rpt_req_if.sink                            req,
  rpt_rsp_if.source                          rsp
);

  rpt_pkg::rpt_cmd_t cmd;
  rpt_pkg::rpt_sts_t sts;

  // Sequence the walk: clear, read/check per level, allocate, write, respond
  rpt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Frame memory, allocator, residue unit, config registers and the output register
  rpt_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .LEVELS     (LEVELS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

// Tracks the expected walk outcome of every accepted request against a private
// copy of the frame memory, the allocator and the two registers.
class walk_scoreboard;
  localparam int NUM_FRAMES = rpt_pkg::NUM_FRAMES_DEF;
  localparam int LEVELS     = rpt_pkg::LEVELS_DEF;
  localparam int INDEX_BITS = rpt_pkg::INDEX_BITS_DEF;
  localparam int ENTRIES    = 1 << INDEX_BITS;
  localparam int PAGE_SHIFT = 12;
  localparam logic [rpt_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic                      found;
    logic [rpt_pkg::PPN_W-1:0] ppn_out;
    logic                      oof;
  } walk_result_t;

  logic [63:0]               frames [NUM_FRAMES*ENTRIES];
  int unsigned               frames_used;
  logic [rpt_pkg::CFG_W-1:0] root_frame;
  logic [rpt_pkg::CFG_W-1:0] first_free;
  walk_result_t              walk_results_due [$];
  int                        mismatches;
  int                        queries, maps, unmaps, unused_reqs, hits, refusals;

  function new();
    foreach (frames[i]) frames[i] = '0;
    frames_used = 0;
    root_frame  = '0;
    first_free  = rpt_pkg::FIRST_FREE_RST;
    mismatches  = 0;
    queries = 0; maps = 0; unmaps = 0; unused_reqs = 0; hits = 0; refusals = 0;
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", what);
  endfunction

  function void write_reg(logic [rpt_pkg::CFG_IDX_W-1:0] idx,
                          logic [rpt_pkg::CFG_W-1:0] data);
    if (idx == rpt_pkg::REG_ROOT_FRAME) root_frame = data;
    else if (idx == rpt_pkg::REG_FIRST_FREE) first_free = data;
  endfunction

  function int unsigned level_idx(logic [rpt_pkg::VPN_W-1:0] vpn, int lvl);
    logic [rpt_pkg::VPN_W-1:0] sh;
    sh = vpn >> ((LEVELS - 1 - lvl) * INDEX_BITS);
    return int'(sh[INDEX_BITS-1:0]);
  endfunction

  function int unsigned slot(int unsigned fr, int unsigned ix);
    return (fr % NUM_FRAMES) * ENTRIES + ix;
  endfunction

  // Work out the result of one request and apply its side effects.
  function void note_request(logic [rpt_pkg::TYPE_W-1:0] kind,
                             logic [rpt_pkg::VPN_W-1:0] vpn,
                             logic [rpt_pkg::PPN_W-1:0] ppn);
    walk_result_t res;
    int unsigned  fr, reached, lvl, nf, k, s;
    logic [63:0]  e;
    res = '0;
    fr = int'(root_frame) % NUM_FRAMES;
    reached = 0;
    while (reached < LEVELS - 1 && frames[slot(fr, level_idx(vpn, reached))][0]) begin
      e = frames[slot(fr, level_idx(vpn, reached))];
      fr = int'((e >> PAGE_SHIFT) % NUM_FRAMES);
      reached++;
    end
    s = slot(fr, level_idx(vpn, LEVELS - 1));
    if (kind == rpt_pkg::REQ_QUERY) begin
      queries++;
      if (reached == LEVELS - 1 && frames[s][0]) begin
        res.found = 1'b1;
        res.ppn_out = frames[s][63:PAGE_SHIFT];
        hits++;
      end
    end else if (kind == rpt_pkg::REQ_MAP) begin
      maps++;
      if (int'(first_free) + frames_used + (LEVELS - 1 - reached) > NUM_FRAMES) begin
        res.oof = 1'b1;
        refusals++;
      end else begin
        for (lvl = reached; lvl < LEVELS - 1; lvl++) begin
          nf = int'(first_free) + frames_used;
          frames_used++;
          for (k = 0; k < ENTRIES; k++) frames[slot(nf, k)] = '0;
          frames[slot(fr, level_idx(vpn, lvl))] = (64'(nf) << PAGE_SHIFT) | 64'd1;
          fr = nf;
        end
        frames[slot(fr, level_idx(vpn, LEVELS - 1))] = {ppn, 12'd1};
        res.found = 1'b1;
      end
    end else if (kind == rpt_pkg::REQ_UNMAP) begin
      unmaps++;
      if (reached == LEVELS - 1) begin
        frames[s][0] = 1'b0;
        res.found = 1'b1;
      end
    end else begin
      unused_reqs++;
    end
    walk_results_due.push_back(res);
  endfunction

  function void check_walk_result(logic found, logic [rpt_pkg::PPN_W-1:0] ppn_out,
                                  logic oof);
    walk_result_t want;
    if (walk_results_due.size() == 0) begin
      flag($sformatf("unexpected result found=%0b ppn_out=%h oof=%0b", found, ppn_out, oof));
      return;
    end
    want = walk_results_due.pop_front();
    if (found !== want.found)
      flag($sformatf("found: expected %0b, got %0b", want.found, found));
    if (ppn_out !== want.ppn_out)
      flag($sformatf("ppn_out: expected %h, got %h", want.ppn_out, ppn_out));
    if (oof !== want.oof)
      flag($sformatf("out_of_frames: expected %0b, got %0b", want.oof, oof));
  endfunction
endclass

module tb;
  localparam int VPN_W = rpt_pkg::VPN_W;
  localparam int PPN_W = rpt_pkg::PPN_W;
  localparam int CFG_W = rpt_pkg::CFG_W;
  localparam logic [rpt_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
  // The clearing pass after reset alone runs without a transfer.
  localparam int QUIET_LIMIT = 150000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 335;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [rpt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  rpt_req_if req_bus ();
  rpt_rsp_if rsp_bus ();

  walk_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int quiet_cycles;

  // Page numbers of earlier maps; random requests mostly reuse their prefixes
  // so that walks get past the top levels despite the small frame pool.
  logic [VPN_W-1:0] mapped_vpns [$];

  radix_page_table_walker uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sample every transfer and register write at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_data);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_walk_result(rsp_bus.found, rsp_bus.ppn_out, rsp_bus.out_of_frames);
      if (req_bus.valid && req_bus.ready)
        sb.note_request(req_bus.req_type, req_bus.vpn, req_bus.ppn);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("radix_page_table_walker: mismatch");
    $finish;
  end

  // Result side: stall at random, or hold off for a long stretch on request.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request from a falling edge and hold it until its transfer.
  task automatic send_req(logic [rpt_pkg::TYPE_W-1:0] kind, logic [VPN_W-1:0] vpn,
                          logic [PPN_W-1:0] ppn);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.vpn      <= vpn;
    req_bus.ppn      <= ppn;
    if (kind == rpt_pkg::REQ_MAP) mapped_vpns.push_back(vpn);
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has arrived.
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(negedge clk); while (sb.walk_results_due.size() != 0);
  endtask

  // Write both registers on consecutive cycles; call only while idle.
  task automatic set_config(logic [CFG_W-1:0] root, logic [CFG_W-1:0] first);
    cfg_we   <= 1'b1;
    cfg_idx  <= rpt_pkg::REG_ROOT_FRAME;
    cfg_data <= root;
    @(negedge clk);
    cfg_idx  <= rpt_pkg::REG_FIRST_FREE;
    cfg_data <= first;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Pick a page number: mostly an earlier map, its leaf neighbors or a nearby
  // subtree, now and then a fresh random one.
  function automatic logic [VPN_W-1:0] pick_vpn();
    logic [63:0]      w;
    logic [VPN_W-1:0] base;
    int               r;
    w = {$urandom(), $urandom()};
    if (mapped_vpns.size() == 0 || $urandom_range(99) < 4) return w[VPN_W-1:0];
    base = mapped_vpns[$urandom_range(mapped_vpns.size() - 1)];
    r = $urandom_range(99);
    if (r < 45) return base;
    if (r < 85) return {base[VPN_W-1:9], w[8:0]};
    if (r < 96) return {base[VPN_W-1:18], w[17:0]};
    return {base[VPN_W-1:27], w[26:0]};
  endfunction

  function automatic logic [PPN_W-1:0] pick_ppn();
    logic [63:0] w;
    int          r;
    w = {$urandom(), $urandom()};
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return w[PPN_W-1:0];
  endfunction

  task automatic run_phase(int send_pct, int recv_pct, logic [CFG_W-1:0] root,
                           logic [CFG_W-1:0] first, bit with_hold, bit with_pause);
    int                          n;
    int                          r;
    logic [rpt_pkg::TYPE_W-1:0]  kind;
    n = 0;
    drain();
    set_config(root, first);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (n < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 38) kind = rpt_pkg::REQ_QUERY;
      else if (r < 70) kind = rpt_pkg::REQ_MAP;
      else if (r < 93) kind = rpt_pkg::REQ_UNMAP;
      else kind = REQ_UNUSED;
      send_req(kind, pick_vpn(), pick_ppn());
      if (kind != REQ_UNUSED) begin
        n++;
        // Block the result side while requests keep coming, so the walker
        // backs up and stalls its input.
        if (with_hold && n == 60) hold_left = HOLD_CYCLES;
        // Pause the request side until the walker has fully emptied.
        if (with_pause && n == PHASE_ITEMS / 2) drain();
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = '0;
    req_bus.vpn      = '0;
    req_bus.ppn      = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_left        = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Reset-value registers: empty table, then build two full paths.
    set_config('0, rpt_pkg::FIRST_FREE_RST);
    send_req(rpt_pkg::REQ_QUERY, '0, '0);
    send_req(rpt_pkg::REQ_UNMAP, '0, '0);
    send_req(rpt_pkg::REQ_MAP, '0, '0);
    send_req(rpt_pkg::REQ_QUERY, '0, '0);
    send_req(rpt_pkg::REQ_MAP, '1, '1);
    send_req(rpt_pkg::REQ_QUERY, '1, '0);
    send_req(rpt_pkg::REQ_MAP, 45'd1, {13{4'hA}});
    send_req(rpt_pkg::REQ_QUERY, 45'd1, '1);
    send_req(rpt_pkg::REQ_UNMAP, '0, '0);
    send_req(rpt_pkg::REQ_QUERY, '0, '0);
    // Unmap of an already cleared leaf still reaches the leaf level.
    send_req(rpt_pkg::REQ_UNMAP, '0, '0);
    send_req(REQ_UNUSED, '1, '1);
    send_req(rpt_pkg::REQ_MAP, '0, {13{4'h5}});
    send_req(rpt_pkg::REQ_QUERY, {23{2'b10}}, '0);

    // Allocator pointer at the top: every map is refused.
    drain();
    set_config('1, '1);
    send_req(rpt_pkg::REQ_MAP, '0, '1);
    send_req(rpt_pkg::REQ_QUERY, '0, '0);

    // Allocator restarted low: new frames overlap tables already in use.
    drain();
    set_config('1, '0);
    send_req(rpt_pkg::REQ_MAP, '0, {13{4'h3}});
    send_req(rpt_pkg::REQ_QUERY, '0, '0);

    drain();
    set_config('0, rpt_pkg::FIRST_FREE_RST);
    send_req(rpt_pkg::REQ_QUERY, '1, '0);
    send_req(rpt_pkg::REQ_QUERY, 45'd1, '0);

    // Root at the next free frame: the first allocation clears the root.
    drain();
    set_config(CFG_W'(sb.first_free + sb.frames_used), rpt_pkg::FIRST_FREE_RST);
    send_req(rpt_pkg::REQ_MAP, '1, {13{4'hC}});
    send_req(rpt_pkg::REQ_QUERY, '1, '0);

    // Random phases under changing idling and register settings.
    run_phase(0, 0, '0, rpt_pkg::FIRST_FREE_RST, 1'b1, 1'b0);
    run_phase(67, 0, '1, '0, 1'b0, 1'b0);
    run_phase(0, 67, CFG_W'($urandom_range(63)), '0, 1'b0, 1'b1);
    run_phase(20, 20, '0, rpt_pkg::FIRST_FREE_RST, 1'b0, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d queries (%0d hits), %0d maps (%0d refused), %0d unmaps, %0d unused",
             sb.queries, sb.hits, sb.maps, sb.refusals, sb.unmaps, sb.unused_reqs);
    $display("Allocator handed out %0d frames; %0d mismatches",
             sb.frames_used, sb.mismatches);
    if (sb.walk_results_due.size() != 0)
      $display("ERROR: %0d results never arrived", sb.walk_results_due.size());
    if (sb.mismatches == 0 && sb.walk_results_due.size() == 0) begin
      $display("radix_page_table_walker: match");
    end else begin
      $display("radix_page_table_walker: mismatch");
    end
    $finish;
  end
endmodule
